// ===== hdl/tmt_pkg.sv =====
package tmt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_SEARCH    = 3'd1,
    ST_MATCH     = 3'd2,
    ST_UNMATCHED = 3'd3,
    ST_TIMEOUT   = 3'd4
  } status_t;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [2:0] REG_TOKEN_BYTES      = 3'd0;
  localparam logic [2:0] REG_TOKEN_LENGTH     = 3'd1;
  localparam logic [2:0] REG_UNMATCHED_BUDGET = 3'd2;
  localparam logic [2:0] REG_FIRST_WAIT_MS    = 3'd3;
  localparam logic [2:0] REG_NEXT_WAIT_MS     = 3'd4;

  typedef enum logic [1:0] {
    OP_START,
    OP_BYTE,
    OP_TICK,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    status_t status;
    logic    finished;
  } result_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [63:0] token_bytes;
    logic [3:0]  token_length;
    logic [15:0] unmatched_budget;
    logic [15:0] first_wait_ms;
    logic [15:0] next_wait_ms;
  } cfg_t;

endpackage

// ===== hdl/tmt_fifo.sv =====
module tmt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fifo count above depth");

  a_ptr_agree: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("fifo pointers disagree with count");

  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    (empty && !push) |=> empty)
    else $error("fifo left empty without a push");

endmodule

// ===== hdl/tmt_front.sv =====
module tmt_front
  import tmt_pkg::*;
(
  input  logic  push,
  input  item_t item,
  output logic  q_push,
  output cmd_t  q_cmd
);

  always_comb begin
    q_push          = push;
    q_cmd.data_byte = item.data_byte;
    case (item.func)
      FUNC_START: q_cmd.op = OP_START;
      FUNC_BYTE:  q_cmd.op = OP_BYTE;
      FUNC_TICK:  q_cmd.op = OP_TICK;
      default:    q_cmd.op = OP_IGNORE;
    endcase
  end

endmodule

// ===== hdl/tmt_back.sv =====
module tmt_back
  import tmt_pkg::*;
#(
  parameter int TOKEN_CHARS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  cmd_t    q_cmd,
  output logic    q_pop,
  input  logic    o_full,
  output logic    o_push,
  output result_t o_result
);

  localparam logic [3:0] MAX_LEN = 4'(TOKEN_CHARS);

  logic [3:0]  match_position, match_position_next;
  logic [16:0] unmatched_count, unmatched_count_next;
  logic [15:0] idle_ms, idle_ms_next;
  logic        searching, searching_next;
  logic        awaiting_first, awaiting_first_next;
  status_t     last_status, last_status_next;

  logic        take;
  logic        done;
  logic [3:0]  len;
  logic [7:0]  cur_char;
  logic [15:0] limit;

  assign take   = !q_empty && !o_full;
  assign q_pop  = take;
  assign o_push = take;
  assign len    = (cfg.token_length > MAX_LEN) ? MAX_LEN : cfg.token_length;
  assign cur_char = cfg.token_bytes[{match_position[2:0], 3'b000} +: 8];
  assign limit  = awaiting_first ? cfg.first_wait_ms : cfg.next_wait_ms;

  always_comb begin
    match_position_next  = match_position;
    unmatched_count_next = unmatched_count;
    idle_ms_next         = idle_ms;
    searching_next       = searching;
    awaiting_first_next  = awaiting_first;
    last_status_next     = last_status;
    done                 = 1'b0;
    case (q_cmd.op)
      OP_START: begin
        match_position_next  = '0;
        unmatched_count_next = '0;
        idle_ms_next         = '0;
        awaiting_first_next  = 1'b1;
        searching_next       = 1'b1;
        last_status_next     = ST_SEARCH;
        if (len == '0) begin
          searching_next   = 1'b0;
          last_status_next = ST_MATCH;
          done             = 1'b1;
        end else if (cfg.first_wait_ms == '0) begin
          searching_next   = 1'b0;
          last_status_next = ST_TIMEOUT;
          done             = 1'b1;
        end
      end
      OP_BYTE: begin
        if (searching) begin
          idle_ms_next        = '0;
          awaiting_first_next = 1'b0;
          if (match_position < len) begin
            if (cur_char == q_cmd.data_byte) begin
              match_position_next = match_position + 1'b1;
            end else if (cfg.token_bytes[7:0] == q_cmd.data_byte) begin
              // the breaking byte opens a new match
              match_position_next  = 4'd1;
              unmatched_count_next = unmatched_count + {13'b0, match_position};
            end else begin
              match_position_next  = '0;
              unmatched_count_next = unmatched_count + {13'b0, match_position} + 17'd1;
            end
          end
          done           = 1'b1;
          searching_next = 1'b0;
          if (match_position_next >= len) begin
            last_status_next = ST_MATCH;
          end else if (unmatched_count_next > {1'b0, cfg.unmatched_budget}) begin
            last_status_next = ST_UNMATCHED;
          end else if (cfg.next_wait_ms == '0) begin
            last_status_next = ST_TIMEOUT;
          end else begin
            done           = 1'b0;
            searching_next = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (searching) begin
          idle_ms_next = (idle_ms == 16'hFFFF) ? idle_ms : idle_ms + 1'b1;
          if (idle_ms_next >= limit) begin
            searching_next   = 1'b0;
            last_status_next = ST_TIMEOUT;
            done             = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    o_result.status   = last_status_next;
    o_result.finished = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_position  <= '0;
      unmatched_count <= '0;
      idle_ms         <= '0;
      searching       <= 1'b0;
      awaiting_first  <= 1'b0;
      last_status     <= ST_IDLE;
    end else if (take) begin
      match_position  <= match_position_next;
      unmatched_count <= unmatched_count_next;
      idle_ms         <= idle_ms_next;
      searching       <= searching_next;
      awaiting_first  <= awaiting_first_next;
      last_status     <= last_status_next;
    end
  end

  a_finish_status: assert property (@(posedge clk) disable iff (rst)
    (o_push && o_result.finished) |->
      (o_result.status == ST_MATCH || o_result.status == ST_UNMATCHED ||
       o_result.status == ST_TIMEOUT))
    else $error("finished result without a final status");

  a_search_status: assert property (@(posedge clk) disable iff (rst)
    searching == (last_status == ST_SEARCH))
    else $error("search flag and status disagree");

  a_finish_ends: assert property (@(posedge clk) disable iff (rst)
    (o_push && o_result.finished) |=> !searching)
    else $error("search still open after finishing transfer");

endmodule

// ===== hdl/token_match_with_timeout.sv =====
// Each pushed item enters the command queue; the execute stage then reads it
// and writes its result into the result queue, from which it can be popped.
// Throughput: one item per cycle while the result queue has room, set by the
// single execute stage updating the match state. Both queues hold 2 entries.
// Reset (rst, synchronous): queues empty, search state cleared, status idle,
// all configuration registers zero.
module token_match_with_timeout
  import tmt_pkg::*;
#(
  parameter int TOKEN_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       item,
  output logic        full,
  input  logic        pop,
  output result_t     result,
  output logic        empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  cfg_t    cfg;
  logic    q_push, q_full, q_empty, q_pop;
  cmd_t    q_wcmd, q_rcmd;
  logic    o_push, o_full;
  result_t o_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOKEN_BYTES:      cfg.token_bytes      <= cfg_data;
        REG_TOKEN_LENGTH:     cfg.token_length     <= cfg_data[3:0];
        REG_UNMATCHED_BUDGET: cfg.unmatched_budget <= cfg_data[15:0];
        REG_FIRST_WAIT_MS:    cfg.first_wait_ms    <= cfg_data[15:0];
        REG_NEXT_WAIT_MS:     cfg.next_wait_ms     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  tmt_front u_front (
    .push   (push),
    .item   (item),
    .q_push (q_push),
    .q_cmd  (q_wcmd)
  );

  assign full = q_full;

  tmt_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rcmd),
    .empty (q_empty)
  );

  tmt_back #(.TOKEN_CHARS(TOKEN_CHARS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_cmd    (q_rcmd),
    .q_pop    (q_pop),
    .o_full   (o_full),
    .o_push   (o_push),
    .o_result (o_result)
  );

  tmt_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .wdata (o_result),
    .full  (o_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tmt_pkg::*;

  localparam int TOKEN_CHARS = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int PRINT_CAP   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  item_t       item = '0;
  logic        full;
  logic        pop = 1'b0;
  result_t     result;
  logic        empty;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  token_match_with_timeout #(.TOKEN_CHARS(TOKEN_CHARS)) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the matcher: configuration and search state.
  cfg_t        shadow_cfg = '0;
  int          match_pos = 0;
  logic [16:0] unmatched_count = '0;
  logic [15:0] idle_ms = '0;
  logic        searching = 1'b0;
  logic        awaiting_first = 1'b0;
  status_t     last_status = ST_IDLE;

  item_t   pending_items[$];
  result_t expected_results[$];

  int   error_count = 0;
  int   items_queued = 0;
  int   push_gap = 0;
  int   pop_gap = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  bit   burst_mode = 1'b0;
  bit   hold_request = 1'b0;

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("%0t ERROR: %s", $time, msg);
  endtask

  function automatic int draw_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      REG_TOKEN_BYTES:      shadow_cfg.token_bytes = val;
      REG_TOKEN_LENGTH:     shadow_cfg.token_length = val[3:0];
      REG_UNMATCHED_BUDGET: shadow_cfg.unmatched_budget = val[15:0];
      REG_FIRST_WAIT_MS:    shadow_cfg.first_wait_ms = val[15:0];
      REG_NEXT_WAIT_MS:     shadow_cfg.next_wait_ms = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic result_t match_step(item_t it);
    int          len;
    logic [7:0]  ch;
    logic [15:0] limit;
    logic        done;
    result_t     r;
    len = (shadow_cfg.token_length > TOKEN_CHARS) ? TOKEN_CHARS : shadow_cfg.token_length;
    done = 1'b0;
    case (it.func)
      FUNC_START: begin
        match_pos = 0;
        unmatched_count = '0;
        idle_ms = '0;
        awaiting_first = 1'b1;
        searching = 1'b1;
        last_status = ST_SEARCH;
        if (len == 0) begin
          searching = 1'b0;
          last_status = ST_MATCH;
          done = 1'b1;
        end else if (shadow_cfg.first_wait_ms == 0) begin
          searching = 1'b0;
          last_status = ST_TIMEOUT;
          done = 1'b1;
        end
      end
      FUNC_BYTE: if (searching) begin
        idle_ms = '0;
        awaiting_first = 1'b0;
        // a shortened token can leave the position at or past the end
        if (match_pos < len) begin
          ch = shadow_cfg.token_bytes[match_pos*8 +: 8];
          if (ch == it.data_byte) begin
            match_pos++;
          end else begin
            unmatched_count = unmatched_count + 17'(match_pos);
            match_pos = 0;
            if (shadow_cfg.token_bytes[7:0] == it.data_byte) match_pos = 1;
            else unmatched_count = unmatched_count + 17'd1;
          end
        end
        done = 1'b1;
        if (match_pos >= len) last_status = ST_MATCH;
        else if (unmatched_count > {1'b0, shadow_cfg.unmatched_budget})
          last_status = ST_UNMATCHED;
        else if (shadow_cfg.next_wait_ms == 0) last_status = ST_TIMEOUT;
        else done = 1'b0;
        if (done) searching = 1'b0;
      end
      FUNC_TICK: if (searching) begin
        limit = awaiting_first ? shadow_cfg.first_wait_ms : shadow_cfg.next_wait_ms;
        if (idle_ms != 16'hFFFF) idle_ms++;
        if (idle_ms >= limit) begin
          searching = 1'b0;
          last_status = ST_TIMEOUT;
          done = 1'b1;
        end
      end
      default: ;
    endcase
    r.status = last_status;
    r.finished = done;
    return r;
  endfunction

  task automatic check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: status %0d finished %0b",
                                got.status, got.finished));
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.finished !== want.finished)
      report_mismatch($sformatf("finished %0b, expected %0b", got.finished, want.finished));
  endtask

  // Input side: accepted items go through the shadow matcher.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(match_step(item));
        push_gap = draw_gap();
      end
      if (!(push && full)) begin
        if (push_gap > 0) begin
          push_gap--;
          push <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item <= pending_items.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_result(result);
        pop_gap = draw_gap();
      end
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ERROR: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic add_item(logic [1:0] func, logic [7:0] data);
    item_t it;
    it.func = func;
    it.data_byte = data;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || push || expected_results.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_wait();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 15) return 16'hFFFF;
    if (r < 85) return 16'($urandom_range(1, 6));
    return 16'($urandom_range(20, 40));
  endfunction

  task automatic pick_settings(bit write_all);
    logic [63:0] tok;
    int          r;
    if (write_all || $urandom_range(99) < 70) begin
      r = $urandom_range(5);
      case (r)
        0: tok = '0;
        1: tok = '1;
        // two-letter alphabet: plenty of partial matches and restarts
        2, 3: for (int i = 0; i < 8; i++) tok[i*8 +: 8] = $urandom_range(1) ? 8'h41 : 8'h42;
        default: tok = {$urandom, $urandom};
      endcase
      write_reg(REG_TOKEN_BYTES, tok);
    end
    if (write_all || $urandom_range(99) < 70) begin
      r = $urandom_range(99);
      if (r < 8) write_reg(REG_TOKEN_LENGTH, 64'd0);
      else if (r < 16) write_reg(REG_TOKEN_LENGTH, 64'($urandom_range(9, 15)));
      else write_reg(REG_TOKEN_LENGTH, 64'($urandom_range(1, 8)));
    end
    if (write_all || $urandom_range(99) < 70) begin
      r = $urandom_range(99);
      if (r < 15) write_reg(REG_UNMATCHED_BUDGET, 64'd0);
      else if (r < 25) write_reg(REG_UNMATCHED_BUDGET, 64'hFFFF);
      else write_reg(REG_UNMATCHED_BUDGET, 64'($urandom_range(1, 10)));
    end
    if (write_all || $urandom_range(99) < 70) write_reg(REG_FIRST_WAIT_MS, 64'(pick_wait()));
    if (write_all || $urandom_range(99) < 70) write_reg(REG_NEXT_WAIT_MS, 64'(pick_wait()));
  endtask

  // One search: a start, then bytes that mostly follow the token.
  task automatic queue_search(int steps);
    int pos;
    int r;
    pos = 0;
    add_item(FUNC_START, 8'($urandom_range(255)));
    repeat (steps) begin
      r = $urandom_range(99);
      if (r < 65) begin
        add_item(FUNC_BYTE, shadow_cfg.token_bytes[pos*8 +: 8]);
        pos = (pos + 1) % TOKEN_CHARS;
      end else if (r < 80) begin
        add_item(FUNC_BYTE, 8'($urandom_range(255)));
        pos = 0;
      end else if (r < 93) begin
        add_item(FUNC_TICK, 8'($urandom_range(255)));
      end else if (r < 97) begin
        add_item(2'd3, 8'($urandom_range(255)));
      end else begin
        add_item(FUNC_START, 8'($urandom_range(255)));
        pos = 0;
      end
    end
  endtask

  initial begin
    int phase;
    int target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: stray items are ignored, empty token matches at once
    add_item(FUNC_BYTE, 8'hFF);
    add_item(2'd3, 8'hAA);
    add_item(FUNC_START, 8'h00);
    add_item(FUNC_TICK, 8'h55);
    wait_drained();

    write_reg(REG_TOKEN_BYTES, 64'h817E_FF00_4341_4241);
    write_reg(REG_TOKEN_LENGTH, 64'd8);
    write_reg(REG_UNMATCHED_BUDGET, 64'd2);
    write_reg(REG_FIRST_WAIT_MS, 64'd2);
    write_reg(REG_NEXT_WAIT_MS, 64'd3);

    // partial match broken by a byte that restarts the token, over budget
    add_item(FUNC_START, 8'h00);
    add_item(FUNC_TICK, 8'h00);
    add_item(FUNC_BYTE, 8'h41);
    add_item(FUNC_BYTE, 8'h42);
    add_item(FUNC_BYTE, 8'h41);
    add_item(FUNC_BYTE, 8'h41);
    // whole token, zero and all-ones characters included
    add_item(FUNC_START, 8'hFF);
    add_item(FUNC_BYTE, 8'h41);
    add_item(FUNC_BYTE, 8'h42);
    add_item(FUNC_BYTE, 8'h41);
    add_item(FUNC_BYTE, 8'h43);
    add_item(FUNC_BYTE, 8'h00);
    add_item(FUNC_BYTE, 8'hFF);
    add_item(FUNC_BYTE, 8'h7E);
    add_item(FUNC_BYTE, 8'h81);
    // restart while searching, then timeout before the first byte
    add_item(FUNC_START, 8'h00);
    add_item(FUNC_BYTE, 8'h41);
    add_item(FUNC_START, 8'h00);
    add_item(FUNC_TICK, 8'h00);
    add_item(FUNC_TICK, 8'hFF);
    wait_drained();

    write_reg(REG_FIRST_WAIT_MS, 64'd0);
    add_item(FUNC_START, 8'h00);
    wait_drained();

    phase = 0;
    while (items_queued < 650) begin
      pick_settings(phase == 0);
      burst_mode = ($urandom_range(3) == 0);
      if (phase == 2) hold_request = 1'b1;
      target = items_queued + $urandom_range(40, 55);
      while (items_queued < target) begin
        if ($urandom_range(9) == 0)
          add_item(2'($urandom_range(1, 3)), 8'($urandom_range(255)));
        else
          queue_search($urandom_range(1, 12));
        // keep offering items while the receiver holds off
        if (phase != 2 && $urandom_range(15) == 0) wait_drained();
      end
      wait_drained();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tmt_pkg.sv
hdl/tmt_fifo.sv
hdl/tmt_front.sv
hdl/tmt_back.sv
hdl/token_match_with_timeout.sv
verif/tb_top.sv
